/* hdl/lsharp_pkg.sv */
package lsharp_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CHANNELS_DEF  = 3;

  // Fixed widths of the port fields.
  localparam int PORT_CH      = 3;
  localparam int SAMPLE_W     = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  // The input row counter saturates at ROW_LIMIT, so it needs ROW_W bits.
  localparam int ROW_W     = 15;
  localparam int ROW_LIMIT = 16384;

  // Smallest frame dimension that the filter works on.
  localparam int MIN_DIM = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // Depth of the result queue in front of the output port.
  localparam int FIFO_DEPTH = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PORT_CH-1:0][SAMPLE_W-1:0] sharp;
    logic                             frame_end;
  } result_t;

endpackage

/* hdl/lsharp_ram.sv */
module lsharp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/laplacian_sharpen_3x3.sv */
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o  pix_c0_i, pix_c1_i, pix_c2_i, frame_start_i,
//                                             is_padding_i
// output    out        out_valid_o / out_stall_i sharp_c0_o, sharp_c1_o, sharp_c2_o,
//                                             frame_end_o
// config    in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// One pixel transaction is accepted per clock while in_stall_o is low. Each transaction passes
// through the position stage, where the line memory read is issued, and then the filter stage,
// where the read data comes back, the 3x3 cross is evaluated and the line memory entry is
// written back; any result is then pushed into the result queue that feeds the output.
// The single-port-per-direction line memory (one read and one write per cycle) sets the rate.
// Reset clears the counters, window registers and queue state; the line memory is not cleared.
// A three-entry result queue absorbs output stalls; the input stalls only when the queue plus
// the transaction in the filter stage could fill it.
module laplacian_sharpen_3x3 #(
  parameter int MAX_WIDTH = lsharp_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = lsharp_pkg::CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lsharp_pkg::SAMPLE_W-1:0]    pix_c0_i,
  input  logic [lsharp_pkg::SAMPLE_W-1:0]    pix_c1_i,
  input  logic [lsharp_pkg::SAMPLE_W-1:0]    pix_c2_i,
  input  logic                               frame_start_i,
  input  logic                               is_padding_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lsharp_pkg::SAMPLE_W-1:0]    sharp_c0_o,
  output logic [lsharp_pkg::SAMPLE_W-1:0]    sharp_c1_o,
  output logic [lsharp_pkg::SAMPLE_W-1:0]    sharp_c2_o,
  output logic                               frame_end_o,

  input  logic                               cfg_we_i,
  input  logic [lsharp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lsharp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int SW     = lsharp_pkg::SAMPLE_W;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = lsharp_pkg::ROW_W;
  localparam int HW     = lsharp_pkg::HEIGHT_REG_W;
  localparam int LANE_W = CHANNELS * SW;
  localparam int RAM_W  = 2 * LANE_W;
  localparam int FD     = lsharp_pkg::FIFO_DEPTH;
  localparam int FPW    = $clog2(FD);
  localparam int FCW    = $clog2(FD + 1);

  // ---------------------------------------------------------------------------------------
  // Configuration registers and their effective values.
  // ---------------------------------------------------------------------------------------
  logic [lsharp_pkg::WIDTH_REG_W-1:0] width_q;
  logic [HW-1:0]                      height_q;
  logic [WW-1:0]                      eff_w;
  logic [HW-1:0]                      eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lsharp_pkg::WIDTH_RESET;
      height_q <= lsharp_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (lsharp_pkg::cfg_reg_e'(cfg_index_i))
        lsharp_pkg::REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[lsharp_pkg::WIDTH_REG_W-1:0];
        end
        lsharp_pkg::REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[HW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The width is clamped into 3..MAX_WIDTH, the height is raised to at least 3.
  always_comb begin
    if (32'(width_q) < lsharp_pkg::MIN_DIM) begin
      eff_w = WW'(lsharp_pkg::MIN_DIM);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (32'(height_q) < lsharp_pkg::MIN_DIM) begin
      eff_h = HW'(lsharp_pkg::MIN_DIM);
    end else begin
      eff_h = height_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Position stage: input position, output position and border decision.
  // ---------------------------------------------------------------------------------------
  logic                in_accept;
  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic [CW-1:0]       col_base;
  logic [CW-1:0]       col_s0;
  logic [RW-1:0]       row_s0;
  logic [WW-1:0]       col_ext;
  logic [WW-1:0]       col_nx;
  logic [RW-1:0]       orow;
  logic [WW-1:0]       ocol;
  logic                emit_s0;
  logic                interior_s0;
  logic                last_s0;
  logic [lsharp_pkg::PORT_CH-1:0][SW-1:0] in_pix;
  logic [LANE_W-1:0]   pix_s0;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_pix    = {pix_c2_i, pix_c1_i, pix_c0_i};

  always_comb begin
    col_base = frame_start_i ? '0 : col_q;
    row_s0   = frame_start_i ? '0 : row_q;
    // A column left beyond a narrowed width wraps to the start of the row.
    col_s0   = (WW'(col_base) >= eff_w) ? '0 : col_base;
    col_ext  = WW'(col_s0);

    // The result belongs to the pixel one row and one column behind the input.
    if (col_s0 != '0) begin
      emit_s0 = row_s0 >= RW'(1);
      orow    = row_s0 - RW'(1);
      ocol    = col_ext - WW'(1);
    end else begin
      emit_s0 = row_s0 >= RW'(2);
      orow    = row_s0 - RW'(2);
      ocol    = eff_w - WW'(1);
    end
    if (orow >= RW'(eff_h)) begin
      emit_s0 = 1'b0;
    end

    interior_s0 = (orow != '0) && ((RW + 1)'(orow) + (RW + 1)'(2) <= (RW + 1)'(eff_h))
               && (ocol != '0) && ((WW + 1)'(ocol) + (WW + 1)'(2) <= (WW + 1)'(eff_w));
    last_s0     = (orow == RW'(eff_h - HW'(1))) && (ocol == eff_w - WW'(1));

    col_nx = col_ext + WW'(1);
    if (col_nx >= eff_w) begin
      col_d = '0;
      row_d = (row_s0 < RW'(lsharp_pkg::ROW_LIMIT)) ? row_s0 + RW'(1) : row_s0;
    end else begin
      col_d = col_nx[CW-1:0];
      row_d = row_s0;
    end
  end

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_pix
    if (ch < lsharp_pkg::PORT_CH) begin : g_port
      assign pix_s0[ch*SW +: SW] = is_padding_i ? '0 : in_pix[ch];
    end else begin : g_none
      assign pix_s0[ch*SW +: SW] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage register between position and filter stages.
  // ---------------------------------------------------------------------------------------
  logic              s1_valid_q;
  logic [CW-1:0]     s1_addr_q;
  logic [LANE_W-1:0] s1_pix_q;
  logic              s1_emit_q;
  logic              s1_interior_q;
  logic              s1_last_q;
  logic              fwd_q;
  logic [RAM_W-1:0]  fwd_data_q;
  logic [RAM_W-1:0]  ram_rdata;
  logic [RAM_W-1:0]  rd_word;
  logic [RAM_W-1:0]  wr_data;
  logic [LANE_W-1:0] up_now;
  logic [LANE_W-1:0] mid_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      // The memory returns stale data when the entry is written in the same cycle
      // as it is read; that happens only when two transactions in a row hit one column.
      fwd_q      <= in_accept && s1_valid_q && (s1_addr_q == col_s0);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
    if (in_accept) begin
      s1_addr_q     <= col_s0;
      s1_pix_q      <= pix_s0;
      s1_emit_q     <= emit_s0;
      s1_interior_q <= interior_s0;
      s1_last_q     <= last_s0;
    end
  end

  // Each memory word holds the upper-line samples above the middle-line samples of
  // one column; both move down by one row when the column is visited.
  lsharp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (in_accept),
    .raddr_i (col_s0),
    .rdata_o (ram_rdata)
  );

  assign rd_word = fwd_q ? fwd_data_q : ram_rdata;
  assign up_now  = rd_word[RAM_W-1:LANE_W];
  assign mid_now = rd_word[LANE_W-1:0];
  assign wr_data = {mid_now, s1_pix_q};

  // ---------------------------------------------------------------------------------------
  // Filter stage: window registers and the cross-shaped kernel per channel.
  // ---------------------------------------------------------------------------------------
  logic [LANE_W-1:0] left_q;
  logic [LANE_W-1:0] centre_q;
  logic [LANE_W-1:0] prev_up_q;
  logic [LANE_W-1:0] prev_down_q;
  logic [LANE_W-1:0] lane_sharp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      centre_q    <= '0;
      prev_up_q   <= '0;
      prev_down_q <= '0;
    end else if (s1_valid_q) begin
      left_q      <= centre_q;
      centre_q    <= mid_now;
      prev_up_q   <= up_now;
      prev_down_q <= s1_pix_q;
    end
  end

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    logic [SW+2:0] pos;
    logic [SW+1:0] neg;
    logic [SW+2:0] diff;

    // Five times the centre, less the four neighbors of the same channel.
    assign pos  = {1'b0, centre_q[ch*SW +: SW], 2'b00} + (SW + 3)'(centre_q[ch*SW +: SW]);
    assign neg  = (SW + 2)'(prev_up_q[ch*SW +: SW]) + (SW + 2)'(prev_down_q[ch*SW +: SW])
                + (SW + 2)'(left_q[ch*SW +: SW]) + (SW + 2)'(mid_now[ch*SW +: SW]);
    assign diff = pos - (SW + 3)'(neg);

    always_comb begin
      if ((SW + 3)'(neg) > pos) begin
        lane_sharp[ch*SW +: SW] = '0;
      end else if (diff > (SW + 3)'({SW{1'b1}})) begin
        lane_sharp[ch*SW +: SW] = '1;
      end else begin
        lane_sharp[ch*SW +: SW] = diff[SW-1:0];
      end
    end
  end

  lsharp_pkg::result_t res_s1;

  for (genvar pc = 0; pc < lsharp_pkg::PORT_CH; pc++) begin : g_res
    if (pc < CHANNELS) begin : g_live
      assign res_s1.sharp[pc] = s1_interior_q ? lane_sharp[pc*SW +: SW] : '0;
    end else begin : g_zero
      assign res_s1.sharp[pc] = '0;
    end
  end
  assign res_s1.frame_end = s1_last_q;

  // ---------------------------------------------------------------------------------------
  // Result queue.
  // ---------------------------------------------------------------------------------------
  lsharp_pkg::result_t fifo_q [FD];
  logic [FPW-1:0]      wr_ptr_q;
  logic [FPW-1:0]      rd_ptr_q;
  logic [FCW-1:0]      cnt_q;
  logic                push;
  logic                pop;
  lsharp_pkg::result_t head;

  assign push = s1_valid_q && s1_emit_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == FPW'(FD - 1)) ? '0 : wr_ptr_q + FPW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FPW'(FD - 1)) ? '0 : rd_ptr_q + FPW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + FCW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - FCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_s1;
    end
  end

  // Room is reserved for the transaction in the filter stage, so the stall does not
  // depend on the output side in the same cycle.
  assign in_stall_o = ((FCW + 1)'(cnt_q) + (FCW + 1)'(s1_valid_q)) >= (FCW + 1)'(FD);

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = cnt_q != '0;
  assign sharp_c0_o  = head.sharp[0];
  assign sharp_c1_o  = head.sharp[1];
  assign sharp_c2_o  = head.sharp[2];
  assign frame_end_o = head.frame_end;

`ifndef NO_ASSERTIONS
  // The result queue never overflows: a full queue excludes a pending filter result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && (cnt_q == FCW'(FD))))
    else $error("result queue full while a filter result is pending");

  // Forwarded line data always belongs to a transaction in the filter stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("line forwarding without a transaction in the filter stage");

  // A result appears at the output only after a transaction left the filter stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_emit_q))
    else $error("output became valid without a filter result");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the 3x3 Laplacian sharpening filter.
//
// The initial block lays out the whole run as a queue of pending transactions and control
// steps. The driver process pops that queue at falling clock edges. The monitor process watches
// both handshakes at rising edges. Every accepted pixel goes through a cycle-free software
// version of the filter, and any sharpened pixel that it yields is queued. Each result that
// the block hands out is checked against the oldest queued pixel.
module tb_top;
  import lsharp_pkg::*;

  localparam int CENTRE_GAIN    = 5;
  localparam int LINE_DEPTH     = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 900;
  localparam int FULL_FRAME     = 32'h7FFF_FFFF;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 10;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef logic [PORT_CH-1:0][SAMPLE_W-1:0] rgb_t;

  // Kinds of entries in the run plan.
  typedef enum logic [2:0] {
    ACT_PIXEL,
    ACT_DRAIN,
    ACT_CFG,
    ACT_HOLD,
    ACT_PACE
  } act_e;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_BINARY,
    FILL_SMOOTH,
    FILL_CHECKER
  } fill_e;

  typedef enum logic {
    PACE_FULL,
    PACE_JITTER
  } pace_e;

  typedef struct packed {
    act_e                  kind;
    rgb_t                  pix;
    logic                  frame_start;
    logic                  padding;
    cfg_reg_e              reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    pace_e                 src_pace;
    pace_e                 sink_pace;
  } plan_t;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  rgb_t                  pix_drv = '0;
  logic                  frame_start_drv = 1'b0;
  logic                  padding_drv = 1'b0;

  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  logic [SAMPLE_W-1:0]   sharp_c0_o;
  logic [SAMPLE_W-1:0]   sharp_c1_o;
  logic [SAMPLE_W-1:0]   sharp_c2_o;
  logic                  frame_end_o;

  logic                  cfg_we = 1'b0;
  cfg_reg_e              cfg_sel = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk_i = ~clk_i;

  laplacian_sharpen_3x3 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .pix_c0_i     (pix_drv[0]),
    .pix_c1_i     (pix_drv[1]),
    .pix_c2_i     (pix_drv[2]),
    .frame_start_i(frame_start_drv),
    .is_padding_i (padding_drv),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .sharp_c0_o   (sharp_c0_o),
    .sharp_c1_o   (sharp_c1_o),
    .sharp_c2_o   (sharp_c2_o),
    .frame_end_o  (frame_end_o),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_sel),
    .cfg_data_i   (cfg_data)
  );

  // Run plan, and sharpened pixels that are still owed by the block.
  plan_t   plan_q[$];
  result_t sharp_exp_q[$];

  // Effective frame size as the plan sees it, and the plan's item count.
  int unsigned plan_w = 640;
  int unsigned plan_h = 480;
  int          plan_items = 0;

  // Software copy of the filter state: registers, line stores, window and position.
  logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  rgb_t        upper_row [LINE_DEPTH];
  rgb_t        middle_row[LINE_DEPTH];
  rgb_t        win_left = '0;
  rgb_t        win_centre = '0;
  rgb_t        win_up = '0;
  rgb_t        win_down = '0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  // Handshake bookkeeping shared between the driver, the sink and the monitor.
  logic  in_fire = 1'b0;
  logic  out_fire = 1'b0;
  int    gap_left = 0;
  int    settle_cnt = 0;
  pace_e src_pace = PACE_FULL;
  pace_e sink_pace = PACE_FULL;
  int    hold_seq = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    stall_left = 0;
  int    idle_cycles = 0;
  int    mismatches = 0;

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int pick_gap(pace_e pace);
    int roll;
    if (pace == PACE_FULL) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic rgb_t rand_rgb();
    logic [31:0] bits;
    bits = $urandom;
    return bits[PORT_CH*SAMPLE_W-1:0];
  endfunction

  // Software filter. Mirrors one accepted pixel transaction and queues the sharpened pixel
  // that it completes, if any. Results trail the input by one row and one column, so the
  // position of the output pixel is derived from the input position.
  function automatic void predict_sharpen(rgb_t pix_in, logic first, logic pad);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned orow;
    int unsigned ocol;
    int          ch;
    int          acc;
    logic        emit;
    logic        interior;
    rgb_t        pix;
    rgb_t        up_now;
    rgb_t        mid_now;
    result_t     want;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (first) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    c = col_pos;
    r = row_pos;
    pix = pad ? '0 : pix_in;
    up_now = upper_row[c];
    mid_now = middle_row[c];

    // At column zero the pixel that completes is the last one of the row two rows back.
    if (c >= 1) begin
      emit = (r >= 1);
      orow = emit ? r - 1 : r;
      ocol = c - 1;
    end else begin
      emit = (r >= 2);
      orow = emit ? r - 2 : r;
      ocol = w - 1;
    end
    if (orow >= h) emit = 1'b0;

    if (emit) begin
      interior = (orow >= 1) && (orow + 2 <= h) && (ocol >= 1) && (ocol + 2 <= w);
      want = '0;
      for (ch = 0; ch < PORT_CH; ch++) begin
        if (interior) begin
          acc = CENTRE_GAIN * int'(win_centre[ch]) - int'(win_up[ch]) - int'(win_down[ch])
              - int'(win_left[ch]) - int'(mid_now[ch]);
          if (acc < 0) want.sharp[ch] = '0;
          else if (acc > 255) want.sharp[ch] = '1;
          else want.sharp[ch] = acc[SAMPLE_W-1:0];
        end
      end
      want.frame_end = (orow == h - 1) && (ocol == w - 1);
      sharp_exp_q.push_back(want);
    end

    win_left = win_centre;
    win_centre = mid_now;
    win_up = up_now;
    win_down = pix;
    upper_row[c] = mid_now;
    middle_row[c] = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < ROW_LIMIT) row_pos++;
    end
  endfunction

  function automatic void note_error(string what, result_t want, result_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected c0=%0d c1=%0d c2=%0d end=%0b, got c0=%0d c1=%0d c2=%0d end=%0b",
               $realtime, what, want.sharp[0], want.sharp[1], want.sharp[2], want.frame_end,
               seen.sharp[0], seen.sharp[1], seen.sharp[2], seen.frame_end);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Plan construction. Every frame begins with frame_start, so each line store entry that
  // can reach an interior result has been written within the same frame and width.
  // ---------------------------------------------------------------------------------------

  function automatic void plan_pixel(rgb_t pix, logic first, logic pad);
    plan_t e;
    e = '0;
    e.kind = ACT_PIXEL;
    e.pix = pix;
    e.frame_start = first;
    e.padding = pad;
    plan_q.push_back(e);
    plan_items++;
  endfunction

  function automatic void plan_step(act_e kind);
    plan_t e;
    e = '0;
    e.kind = kind;
    plan_q.push_back(e);
  endfunction

  function automatic void plan_pace(pace_e src, pace_e sink);
    plan_t e;
    e = '0;
    e.kind = ACT_PACE;
    e.src_pace = src;
    e.sink_pace = sink;
    plan_q.push_back(e);
  endfunction

  // Register writes wait for the block to drain, so they always land while it is idle.
  function automatic void plan_cfg(cfg_reg_e sel, int raw);
    plan_t e;
    int    field;
    plan_step(ACT_DRAIN);
    e = '0;
    e.kind = ACT_CFG;
    e.reg_sel = sel;
    e.reg_val = raw[CFG_DATA_W-1:0];
    plan_q.push_back(e);
    if (sel == REG_IMAGE_WIDTH) begin
      field = raw & ((1 << WIDTH_REG_W) - 1);
      if (field < MIN_DIM) field = MIN_DIM;
      if (field > LINE_DEPTH) field = LINE_DEPTH;
      plan_w = field;
    end else begin
      field = raw & ((1 << HEIGHT_REG_W) - 1);
      if (field < MIN_DIM) field = MIN_DIM;
      plan_h = field;
    end
  endfunction

  // One frame of plan_w by plan_h pixels. A cut below the frame size ends it early, and the
  // next frame then restarts the position counters mid-stream. A full frame is followed by
  // width+1 flush transactions that push out the last row.
  function automatic void plan_frame(fill_e fill, int cut);
    int   total;
    int   n;
    int   ch;
    int   row;
    int   col;
    int   base;
    int   lvl;
    logic pad;
    rgb_t pix;
    total = plan_w * plan_h;
    base = $urandom_range(200, 40);
    for (n = 0; n < total && n < cut; n++) begin
      row = n / plan_w;
      col = n % plan_w;
      pix = rand_rgb();
      for (ch = 0; ch < PORT_CH; ch++) begin
        case (fill)
          FILL_BINARY: begin
            pix[ch] = $urandom_range(1) ? 8'hFF : 8'h00;
          end
          FILL_SMOOTH: begin
            lvl = base + int'($urandom_range(20)) - 10;
            pix[ch] = lvl[SAMPLE_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // Checkerboard on the first two channels drives the sum to both saturation limits.
      if (fill == FILL_CHECKER) begin
        pix[0] = ((row + col) % 2 != 0) ? 8'hFF : 8'h00;
        pix[1] = ~pix[0];
      end
      // A flush transaction inside the frame stands for a black pixel.
      pad = (fill == FILL_RANDOM) && ($urandom_range(39) == 0);
      plan_pixel(pix, n == 0, pad);
    end
    if (cut >= total) begin
      for (n = 0; n <= plan_w; n++) plan_pixel(rand_rgb(), 1'b0, 1'b1);
    end
  endfunction

  // Stray transactions after a frame; past the end of a full frame they must not produce results.
  function automatic void plan_tail(int count);
    int n;
    for (n = 0; n < count; n++) plan_pixel(rand_rgb(), 1'b0, logic'($urandom_range(1)));
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: offers the head of the plan at falling edges and holds each pixel transaction
  // until it is taken. Idle cycles carry random payload with valid low.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin : pixel_driver
    plan_t head;
    logic  valid_n;
    logic  we_n;
    logic  fs_n;
    logic  pad_n;
    rgb_t  pix_n;
    valid_n = in_valid;
    we_n = 1'b0;
    pix_n = pix_drv;
    fs_n = frame_start_drv;
    pad_n = padding_drv;
    if (rst_n && !(in_valid && !in_fire)) begin
      valid_n = 1'b0;
      pix_n = rand_rgb();
      fs_n = $urandom_range(1);
      pad_n = $urandom_range(1);
      if (gap_left != 0) begin
        gap_left--;
      end else if (plan_q.size() != 0) begin
        head = plan_q[0];
        case (head.kind)
          ACT_PIXEL: begin
            valid_n = 1'b1;
            pix_n = head.pix;
            fs_n = head.frame_start;
            pad_n = head.padding;
            gap_left = pick_gap(src_pace);
            void'(plan_q.pop_front());
          end
          ACT_DRAIN: begin
            // Wait for every owed result, then let the settle counter run out in case the last
            // transactions were ones that complete no pixel.
            if (sharp_exp_q.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt < SETTLE_CYCLES) begin
              settle_cnt++;
            end else begin
              settle_cnt = 0;
              void'(plan_q.pop_front());
            end
          end
          ACT_CFG: begin
            we_n = 1'b1;
            cfg_sel <= head.reg_sel;
            cfg_data <= head.reg_val;
            void'(plan_q.pop_front());
          end
          ACT_HOLD: begin
            hold_seq <= hold_seq + 1;
            void'(plan_q.pop_front());
          end
          default: begin
            src_pace = head.src_pace;
            sink_pace <= head.sink_pace;
            void'(plan_q.pop_front());
          end
        endcase
      end
    end
    in_valid <= valid_n;
    cfg_we <= we_n;
    pix_drv <= pix_n;
    frame_start_drv <= fs_n;
    padding_drv <= pad_n;
  end

  // Sink: random stalls on the result side, plus a long hold-off on request so that the
  // result queue fills and the block has to stall its input.
  always @(negedge clk_i) begin : result_sink
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(sink_pace);
    end
  end

  // Monitor: register writes and pixel transactions feed the software filter; each result
  // transaction is checked field by field against the oldest owed pixel.
  always @(posedge clk_i) begin : stream_monitor
    result_t seen;
    result_t want;
    int      ch;
    logic    bad;
    if (rst_n) begin
      in_fire = in_valid && !in_stall_o;
      out_fire = out_valid_o && !out_stall;
      if (cfg_we) begin
        case (cfg_sel)
          REG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_REG_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_fire) begin
        seen.sharp[0] = sharp_c0_o;
        seen.sharp[1] = sharp_c1_o;
        seen.sharp[2] = sharp_c2_o;
        seen.frame_end = frame_end_o;
        if (sharp_exp_q.size() == 0) begin
          note_error("result with no pixel owed", '0, seen);
        end else begin
          want = sharp_exp_q.pop_front();
          bad = (seen.frame_end !== want.frame_end);
          for (ch = 0; ch < PORT_CH; ch++) begin
            if (seen.sharp[ch] !== want.sharp[ch]) bad = 1'b1;
          end
          if (bad) note_error("sharpened pixel mismatch", want, seen);
        end
      end
      if (in_fire) predict_sharpen(pix_drv, frame_start_drv, padding_drv);
      if (in_fire || out_fire || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Watchdog: too long without any transaction means the block has hung.
  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : run_control
    int    random_base;
    int    frames;
    int    f;
    int    roll;
    int    raw;
    int    cut;
    fill_e fill;

    for (f = 0; f < LINE_DEPTH; f++) begin
      upper_row[f] = '0;
      middle_row[f] = '0;
    end

    // Directed opening: a 4x4 checkerboard saturates high and low on its four interior
    // pixels, then a few stray transactions past the frame must stay silent.
    plan_pace(PACE_FULL, PACE_FULL);
    plan_cfg(REG_IMAGE_WIDTH, 4);
    plan_cfg(REG_IMAGE_HEIGHT, 4);
    plan_frame(FILL_CHECKER, FULL_FRAME);
    plan_tail(3);

    // Random phases: small frames, mixed content, truncated frames, clamped sizes.
    random_base = plan_items;
    while (plan_items - random_base < RANDOM_ITEMS) begin
      plan_pace(pace_e'($urandom_range(1)), pace_e'($urandom_range(1)));
      if ($urandom_range(1) != 0) begin
        roll = $urandom_range(99);
        if (roll < 70) raw = $urandom_range(12, 3);
        else if (roll < 85) raw = $urandom_range(2, 0);
        else raw = $urandom_range(24, 13);
        // Bits above the width field must be ignored.
        raw = raw | ($urandom_range(3) << WIDTH_REG_W);
        plan_cfg(REG_IMAGE_WIDTH, raw);
      end
      if ($urandom_range(1) != 0) begin
        roll = $urandom_range(99);
        if (roll < 70) raw = $urandom_range(8, 3);
        else if (roll < 85) raw = $urandom_range(2, 0);
        else raw = $urandom_range(14, 9);
        plan_cfg(REG_IMAGE_HEIGHT, raw);
      end
      frames = $urandom_range(3, 1);
      for (f = 0; f < frames; f++) begin
        fill = fill_e'($urandom_range(3));
        cut = ($urandom_range(4) == 0) ? $urandom_range(plan_w * plan_h - 1, 1) : FULL_FRAME;
        plan_frame(fill, cut);
      end
      plan_tail($urandom_range(4));
      // Sometimes the sender simply waits for the block to empty.
      if ($urandom_range(3) == 0) plan_step(ACT_DRAIN);
    end

    // Widest line (width field all ones, clamped) with the height raised to its minimum.
    // The sink holds off for a long stretch while the sender keeps offering pixels.
    plan_pace(PACE_FULL, PACE_FULL);
    plan_cfg(REG_IMAGE_WIDTH, (1 << WIDTH_REG_W) - 1);
    plan_cfg(REG_IMAGE_HEIGHT, 0);
    plan_step(ACT_HOLD);
    plan_frame(FILL_SMOOTH, FULL_FRAME);

    // Narrowest line with the tallest frame the height field can hold.
    plan_cfg(REG_IMAGE_WIDTH, 0);
    plan_cfg(REG_IMAGE_HEIGHT, (1 << HEIGHT_REG_W) - 1);
    plan_frame(FILL_BINARY, FULL_FRAME);
    plan_tail(4);

    // Reset is released at a falling edge, away from the rising edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    while (plan_q.size() != 0 || in_valid || sharp_exp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
